>>> rtl/apf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apf_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int NODE_W        = 6;
    localparam int CNT_W         = 7;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_SEEK  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_BACK  = 8'b0010_0000,
        S_POP   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

>>> rtl/articulation_point_finder.sv
`timescale 1ns / 1ps
`default_nettype none

// Articulation point finder for undirected graphs of up to MAX_NODES nodes.
//
// Edge transactions are taken on the command channel (i_start while o_busy is
// low), one per cycle while the block is loading. Each edge sets a bit in two
// adjacency memories, one per direction, so an edge needs only one write per
// memory. Self-loops and endpoints at or beyond MAX_NODES are dropped.
// The transaction with i_last_edge high raises o_busy and starts a depth-first
// search over nodes 0 to N-1, N being the active node count: node_count, with
// zero counted as one and counts above MAX_NODES saturated. The search holds
// its frames in a stack memory and discovery numbers in a node memory. The
// neighbor cursor walks one adjacency bit per cycle while in the scan state, and
// every visited neighbor other than the parent costs an extra back state to
// fetch its discovery number.
// After the search, one result per node is shown for exactly one cycle on
// o_result_valid, in ascending order, the last marked by o_last_result. The
// receiver cannot stall these results.
// After the results the adjacency memories are cleared, one row per cycle,
// and the block takes edges again. The same clearing pass runs after reset,
// so o_busy stays high after reset until every row has been cleared.
// node_count is written on the configuration channel, which is always ready
// and must only be used while the block is idle.
module articulation_point_finder
    import apf_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_edge_valid,
    input  wire logic [NODE_W-1:0] i_edge_from,
    input  wire logic [NODE_W-1:0] i_edge_to,
    input  wire logic              i_last_edge,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output logic                   o_result_valid,
    output logic [NODE_W-1:0]      o_node_index,
    output logic                   o_is_articulation,
    output logic                   o_last_result
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DW = AW + 1;

    // One suspended search frame.
    typedef struct packed {
        logic [AW-1:0]    node;
        logic [AW-1:0]    parent;
        logic             has_parent;
        logic [DW-1:0]    cursor;
        logic [CNT_W-1:0] low;
        logic [CNT_W-1:0] disc;
    } t_frame;

    // Memories.
    logic [MAX_NODES-1:0] r_adj_fwd [MAX_NODES];
    logic [MAX_NODES-1:0] r_adj_rev [MAX_NODES];
    logic [CNT_W-1:0]     r_disc_mem [MAX_NODES];
    t_frame               r_stack [MAX_NODES];

    logic [MAX_NODES-1:0] r_row_fwd;
    logic [MAX_NODES-1:0] r_row_rev;
    logic [CNT_W-1:0]     r_disc_rd;
    t_frame               r_stk_rd;

    // Control and current frame.
    t_state               r_state;
    logic [CNT_W-1:0]     r_node_count;
    logic [MAX_NODES-1:0] r_visited;
    logic [MAX_NODES-1:0] r_artic;
    logic [DW-1:0]        r_depth;
    logic [CNT_W-1:0]     r_clock;
    logic [CNT_W-1:0]     r_root_kids;
    logic [DW-1:0]        r_root;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_u;
    logic [AW-1:0]        r_par;
    logic                 r_hasp;
    logic [DW-1:0]        r_c;
    logic [CNT_W-1:0]     r_low;
    logic [CNT_W-1:0]     r_disc;

    logic [DW-1:0]        n_active;
    logic [MAX_NODES-1:0] row;
    logic [AW-1:0]        cur_bit;
    logic                 edge_ok;
    logic                 accept;
    logic [CNT_W-1:0]     n_clock;
    logic [AW-1:0]        stk_wr_addr;
    logic [AW-1:0]        stk_rd_addr;
    logic [CNT_W-1:0]     pop_low;

    // Zero counts as one node; counts above MAX_NODES saturate.
    always_comb begin
        if (r_node_count == '0) begin
            n_active = DW'(1);
        end else if (r_node_count > CNT_W'(MAX_NODES)) begin
            n_active = DW'(MAX_NODES);
        end else begin
            n_active = DW'(r_node_count);
        end
    end

    assign row         = r_row_fwd | r_row_rev;
    assign cur_bit     = r_c[AW-1:0];
    assign accept      = i_start && (r_state == S_LOAD);
    assign edge_ok     = i_edge_valid && (i_edge_from != i_edge_to)
                         && ({1'b0, i_edge_from} < CNT_W'(MAX_NODES))
                         && ({1'b0, i_edge_to} < CNT_W'(MAX_NODES));
    assign n_clock     = r_clock + CNT_W'(1);
    assign stk_wr_addr = AW'(r_depth - DW'(1));
    assign stk_rd_addr = AW'(r_depth - DW'(2));
    assign pop_low     = (r_low < r_stk_rd.low) ? r_low : r_stk_rd.low;

    assign o_busy            = (r_state != S_LOAD);
    assign o_cfg_ready       = 1'b1;
    assign o_result_valid    = (r_state == S_EMIT);
    assign o_node_index      = NODE_W'(r_idx);
    assign o_is_articulation = r_artic[r_idx];
    assign o_last_result     = ({1'b0, r_idx} == n_active - DW'(1));

    // Adjacency memories: bit writes while loading, row writes while clearing.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_adj_fwd[r_idx] <= '0;
            r_adj_rev[r_idx] <= '0;
        end else if (accept && edge_ok) begin
            r_adj_fwd[i_edge_from[AW-1:0]][i_edge_to[AW-1:0]] <= 1'b1;
            r_adj_rev[i_edge_to[AW-1:0]][i_edge_from[AW-1:0]] <= 1'b1;
        end
        r_row_fwd <= r_adj_fwd[r_u];
        r_row_rev <= r_adj_rev[r_u];
    end

    // Discovery numbers and the frame stack.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEEK && r_root < n_active && !r_visited[r_root[AW-1:0]]) begin
            r_disc_mem[r_root[AW-1:0]] <= n_clock;
        end else if (r_state == S_SCAN && r_c < n_active && row[cur_bit]
                     && !r_visited[cur_bit]) begin
            r_disc_mem[cur_bit] <= n_clock;
            r_stack[stk_wr_addr] <= '{node: r_u, parent: r_par, has_parent: r_hasp,
                                      cursor: r_c + DW'(1), low: r_low, disc: r_disc};
        end
        r_disc_rd <= r_disc_mem[cur_bit];
        r_stk_rd  <= r_stack[stk_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_node_count <= CNT_W'(64);
            r_idx        <= '0;
            r_depth      <= '0;
            r_clock      <= '0;
            r_root_kids  <= '0;
            r_root       <= '0;
            r_visited    <= '0;
            r_artic      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == AW'(MAX_NODES - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (accept && i_last_edge) begin
                        r_visited <= '0;
                        r_artic   <= '0;
                        r_clock   <= '0;
                        r_root    <= '0;
                        r_state   <= S_SEEK;
                    end
                end
                S_SEEK: begin
                    if (r_root >= n_active) begin
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end else if (r_visited[r_root[AW-1:0]]) begin
                        r_root <= r_root + DW'(1);
                    end else begin
                        r_visited[r_root[AW-1:0]] <= 1'b1;
                        r_clock     <= n_clock;
                        r_u         <= r_root[AW-1:0];
                        r_par       <= '0;
                        r_hasp      <= 1'b0;
                        r_c         <= '0;
                        r_low       <= n_clock;
                        r_disc      <= n_clock;
                        r_depth     <= DW'(1);
                        r_root_kids <= '0;
                        r_state     <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_c >= n_active) begin
                        r_depth <= r_depth - DW'(1);
                        if (r_depth == DW'(1)) begin
                            r_root  <= r_root + DW'(1);
                            r_state <= S_SEEK;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_c <= r_c + DW'(1);
                        if (row[cur_bit]) begin
                            if (!r_visited[cur_bit]) begin
                                // Descend into a tree child.
                                r_visited[cur_bit] <= 1'b1;
                                r_clock <= n_clock;
                                r_u     <= cur_bit;
                                r_par   <= r_u;
                                r_hasp  <= 1'b1;
                                r_c     <= '0;
                                r_low   <= n_clock;
                                r_disc  <= n_clock;
                                r_depth <= r_depth + DW'(1);
                                r_state <= S_FETCH;
                            end else if (!(r_hasp && r_par == cur_bit)) begin
                                // Back edge: its discovery number arrives next cycle.
                                r_state <= S_BACK;
                            end
                        end
                    end
                end
                S_BACK: begin
                    if (r_disc_rd < r_low) begin
                        r_low <= r_disc_rd;
                    end
                    r_state <= S_SCAN;
                end
                S_POP: begin
                    if (r_depth == DW'(1)) begin
                        r_root_kids <= r_root_kids + CNT_W'(1);
                        if (r_root_kids != '0) begin
                            r_artic[r_stk_rd.node] <= 1'b1;
                        end
                    end else if (r_low >= r_stk_rd.disc) begin
                        r_artic[r_stk_rd.node] <= 1'b1;
                    end
                    r_u     <= r_stk_rd.node;
                    r_par   <= r_stk_rd.parent;
                    r_hasp  <= r_stk_rd.has_parent;
                    r_c     <= r_stk_rd.cursor;
                    r_low   <= pop_low;
                    r_disc  <= r_stk_rd.disc;
                    r_state <= S_FETCH;
                end
                S_EMIT: begin
                    r_idx <= r_idx + AW'(1);
                    if (o_last_result) begin
                        r_idx   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // The final result is always followed by the clearing pass.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last_result |=> r_state == S_CLEAR)
        else $error("clearing pass did not follow the final result");

    // The stack never grows beyond the active node count.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= n_active)
        else $error("stack depth exceeds node count");

    // A scan always has a frame on the stack.
    a_scan_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_depth != '0)
        else $error("scan with empty stack");

    // The item that ends a graph starts the search.
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_edge |=> r_state == S_SEEK)
        else $error("search did not start after the final edge");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

// Testbench for articulation_point_finder.
// Graphs are loaded one edge transaction at a time. On the last edge of a
// graph the testbench runs its own depth-first search over the mirrored
// adjacency matrix. It then queues one expected flag per node, and the result
// monitor checks them in order.
module tb;
    import apf_pkg::*;

    localparam int NODES     = DEF_MAX_NODES;
    localparam int IDLE_MAX  = 60000;  // covers a full 64-node search and clearing pass
    localparam int SETTLE    = 100;

    typedef struct {
        logic              edge_valid;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic              last_edge;
        int                gap;
    } t_edge_item;

    typedef struct {
        logic [NODE_W-1:0] node_index;
        logic              is_articulation;
        logic              last_result;
    } t_node_flag;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic              i_edge_valid;
    logic [NODE_W-1:0] i_edge_from;
    logic [NODE_W-1:0] i_edge_to;
    logic              i_last_edge;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;
    logic              o_result_valid;
    logic [NODE_W-1:0] o_node_index;
    logic              o_is_articulation;
    logic              o_last_result;

    articulation_point_finder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_edge_valid     (i_edge_valid),
        .i_edge_from      (i_edge_from),
        .i_edge_to        (i_edge_to),
        .i_last_edge      (i_last_edge),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_node_index     (o_node_index),
        .o_is_articulation(o_is_articulation),
        .o_last_result    (o_last_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    t_edge_item        pending_edges[$];
    t_node_flag        expected_flags[$];
    logic [NODES-1:0]  adj_mirror[NODES];
    logic [CNT_W-1:0]  node_count_mirror;
    logic              edge_taken;
    int                waited;
    int                errors;
    int                edges_sent;
    int                graphs_done;
    int                flags_seen;
    int                cut_flags_seen;
    int                idle_cycles;

    // Clamp the node count the way the block does: zero acts as one and
    // anything above the maximum saturates.
    function automatic int active_count(input logic [CNT_W-1:0] cnt);
        if (cnt == 0) return 1;
        if (cnt > NODES) return NODES;
        return int'(cnt);
    endfunction

    // Iterative Tarjan search over nodes 0..n-1. Neighbors are taken in
    // ascending order, and each stack frame remembers where its scan stopped.
    function automatic logic [NODES-1:0] find_cut_nodes(input int n);
        logic [NODES-1:0] cut;
        logic [NODES-1:0] seen;
        logic [NODES-1:0] row;
        int disc[NODES];
        int low[NODES];
        int frame_node[NODES];
        int frame_cursor[NODES];
        int depth;
        int clk_no;
        int kids;
        int u;
        int p;
        int v;
        cut = '0;
        seen = '0;
        clk_no = 0;
        for (int r = 0; r < n; r++) begin
            if (!seen[r]) begin
                kids = 0;
                clk_no++;
                seen[r] = 1'b1;
                disc[r] = clk_no;
                low[r] = clk_no;
                frame_node[0] = r;
                frame_cursor[0] = 0;
                depth = 1;
                while (depth > 0) begin
                    u = frame_node[depth-1];
                    v = -1;
                    row = adj_mirror[u];
                    for (int k = frame_cursor[depth-1]; k < n; k++) begin
                        if (row[k] && v < 0) v = k;
                    end
                    if (v < 0) begin
                        // Scan of u is finished: fold its low value into the parent.
                        depth--;
                        if (depth > 0) begin
                            p = frame_node[depth-1];
                            if (low[u] < low[p]) low[p] = low[u];
                            if (depth == 1) begin
                                kids++;
                                if (kids > 1) cut[p] = 1'b1;
                            end else if (low[u] >= disc[p]) begin
                                cut[p] = 1'b1;
                            end
                        end
                    end else begin
                        frame_cursor[depth-1] = v + 1;
                        if (!seen[v]) begin
                            clk_no++;
                            seen[v] = 1'b1;
                            disc[v] = clk_no;
                            low[v] = clk_no;
                            frame_node[depth] = v;
                            frame_cursor[depth] = 0;
                            depth++;
                        end else if (!(depth > 1 && frame_node[depth-2] == v)) begin
                            if (disc[v] < low[u]) low[u] = disc[v];
                        end
                    end
                end
            end
        end
        return cut;
    endfunction

    // Input side monitor and predictor: every accepted transaction with a valid
    // non-loop edge updates the mirror, and the last transaction produces the expected flags.
    always @(posedge i_clk) begin
        logic [NODES-1:0] cut;
        int n;
        edge_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) node_count_mirror = i_cfg_data;
            if (i_start && !o_busy) begin
                edge_taken = 1'b1;
                edges_sent++;
                if (i_edge_valid && i_edge_from != i_edge_to) begin
                    adj_mirror[i_edge_from][i_edge_to] = 1'b1;
                    adj_mirror[i_edge_to][i_edge_from] = 1'b1;
                end
                if (i_last_edge) begin
                    n = active_count(node_count_mirror);
                    cut = find_cut_nodes(n);
                    for (int k = 0; k < n; k++) begin
                        expected_flags.push_back('{NODE_W'(k), cut[k], k == n - 1});
                    end
                    for (int k = 0; k < NODES; k++) adj_mirror[k] = '0;
                    graphs_done++;
                end
            end
        end
    end

    // Result monitor: the receiver cannot stall, so every strobe is checked.
    always @(posedge i_clk) begin
        t_node_flag want;
        if (i_rst_n && o_result_valid) begin
            flags_seen++;
            if (o_is_articulation) cut_flags_seen++;
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected result node %0d flag %0b last %0b", $time,
                         o_node_index, o_is_articulation, o_last_result);
                errors++;
            end else begin
                want = expected_flags.pop_front();
                if (o_node_index !== want.node_index) begin
                    $display("%0t: node_index expected %0d actual %0d", $time,
                             want.node_index, o_node_index);
                    errors++;
                end
                if (o_is_articulation !== want.is_articulation) begin
                    $display("%0t: is_articulation of node %0d expected %0b actual %0b",
                             $time, want.node_index, want.is_articulation,
                             o_is_articulation);
                    errors++;
                end
                if (o_last_result !== want.last_result) begin
                    $display("%0t: last_result of node %0d expected %0b actual %0b",
                             $time, want.node_index, want.last_result, o_last_result);
                    errors++;
                end
            end
        end
    end

    // Driver: inputs change on the falling edge. Each edge transaction waits
    // its own gap before start goes high, and start then stays high
    // until the block takes it.
    always @(negedge i_clk) begin
        logic next_start;
        t_edge_item it;
        next_start = i_start;
        if (i_rst_n) begin
            if (edge_taken) begin
                void'(pending_edges.pop_front());
                next_start = 1'b0;
                waited = 0;
            end
            if (!next_start && pending_edges.size() > 0) begin
                it = pending_edges[0];
                if (waited < it.gap) begin
                    waited++;
                end else begin
                    i_edge_valid <= it.edge_valid;
                    i_edge_from  <= it.from_node;
                    i_edge_to    <= it.to_node;
                    i_last_edge  <= it.last_edge;
                    next_start = 1'b1;
                end
            end
        end
        i_start <= next_start;
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || edge_taken || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_flags.size());
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_edge(input logic ev, input int a, input int b, input logic last,
                            input int gap);
        pending_edges.push_back('{ev, NODE_W'(a), NODE_W'(b), last, gap});
    endtask

    // Wait until every queued edge is taken and every result has come, then
    // let the clearing pass and the block's latency run out.
    task automatic drain();
        while (pending_edges.size() > 0 || expected_flags.size() > 0 || i_start) begin
            @(posedge i_clk);
        end
        while (o_busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_node_count(input int cnt);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CNT_W'(cnt);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random graph. Most endpoints fall inside the active node range,
    // a few anywhere in the field, and some transactions carry no edge.
    task automatic random_graph(input int cnt, input bit no_gaps);
        int n;
        int m;
        int a;
        int b;
        logic ev;
        n = active_count(CNT_W'(cnt));
        m = $urandom_range(0, (n > 8) ? 3 * n / 2 : 2 * n + 1);
        if (m > 14) m = $urandom_range(6, 14);
        for (int k = 0; k <= m; k++) begin
            ev = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, NODES - 1);
                b = $urandom_range(0, NODES - 1);
            end else begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
            end
            add_edge(ev, a, b, k == m, no_gaps ? 0 : $urandom_range(0, 7));
        end
    endtask

    initial begin
        int cnt;
        errors = 0;
        edges_sent = 0;
        graphs_done = 0;
        flags_seen = 0;
        cut_flags_seen = 0;
        waited = 0;
        idle_cycles = 0;
        edge_taken = 1'b0;
        node_count_mirror = CNT_W'(NODES);
        for (int k = 0; k < NODES; k++) adj_mirror[k] = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_edge_valid = 1'b0;
        i_edge_from = '0;
        i_edge_to = '0;
        i_last_edge = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset count of 64: a path from node 0 through node 63 to node 62, plus a repeated
        // edge and a self-loop, closed by a transaction that carries no edge.
        add_edge(1'b1, 0, 63, 1'b0, 0);
        add_edge(1'b1, 63, 0, 1'b0, 3);
        add_edge(1'b1, 5, 5, 1'b0, 0);
        add_edge(1'b1, 63, 62, 1'b0, 7);
        add_edge(1'b0, 63, 63, 1'b1, 1);
        drain();

        // Four-node path: the inner nodes are cut points.
        write_node_count(4);
        add_edge(1'b1, 0, 1, 1'b0, 0);
        add_edge(1'b1, 2, 1, 1'b0, 0);
        add_edge(1'b1, 2, 3, 1'b0, 2);
        add_edge(1'b0, 0, 0, 1'b1, 0);
        drain();

        // Count zero acts as a single node; the self-loop adds nothing.
        write_node_count(0);
        add_edge(1'b1, 0, 0, 1'b1, 0);
        drain();

        // Count 1 with an edge beyond the active range.
        write_node_count(1);
        add_edge(1'b1, 0, 42, 1'b1, 4);
        drain();

        // Triangle with a bridge and an edge past the node count, which the
        // search must not see.
        write_node_count(6);
        add_edge(1'b1, 0, 1, 1'b0, 0);
        add_edge(1'b1, 1, 2, 1'b0, 0);
        add_edge(1'b1, 2, 0, 1'b0, 0);
        add_edge(1'b1, 2, 3, 1'b0, 0);
        add_edge(1'b1, 3, 50, 1'b0, 0);
        add_edge(1'b1, 4, 5, 1'b1, 0);
        drain();

        // Count above the maximum saturates: a star whose root has three trees.
        write_node_count(127);
        add_edge(1'b1, 0, 1, 1'b0, 0);
        add_edge(1'b1, 0, 2, 1'b0, 0);
        add_edge(1'b1, 3, 0, 1'b1, 0);
        drain();

        // Random graphs, changing the node count every few graphs and
        // including full-size ones now and then.
        cnt = 127;
        while (edges_sent < 220) begin
            case ($urandom_range(0, 11))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = 64;
                3: cnt = $urandom_range(65, 127);
                4, 5: cnt = 2;
                default: cnt = $urandom_range(3, 12);
            endcase
            write_node_count(cnt);
            repeat ($urandom_range(1, 3)) begin
                random_graph(cnt, $urandom_range(0, 3) == 0);
            end
            drain();
        end

        $display("Covered %0d edge transactions over %0d graphs, node counts 0 to 127.",
                 edges_sent, graphs_done);
        $display("Checked %0d node results, %0d of them articulation points.",
                 flags_seen, cut_flags_seen);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/apf_pkg.sv
rtl/articulation_point_finder.sv
tb/tb.sv
